### rtl/indexed_list_insert_remove_assert.svh
// Assertion helpers used by the list design file.
`ifndef INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ILIR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ILIR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ilir_pkg.sv
package ilir_pkg;

    // Fixed field widths of the list ports.
    localparam int OP_W    = 3;
    localparam int INDEX_W = 8;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;
    localparam int LIMIT_W = 5;

    // Width used to carry a stored word between the port and the storage width.
    localparam int EXT_W = 64;

    // Width of the index, count and limit comparisons.
    localparam int CMP_W = 9;

    // Size limit after reset.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd17;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_GET    = 3'd0;
    localparam logic [OP_W-1:0] OP_SET    = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    // Sequencer states.
    typedef enum logic [2:0]
    {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_SHIFT,
        S_FINAL,
        S_RESP
    } state_t;

endpackage

### rtl/ilir_ram.sv
module ilir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/indexed_list_insert_remove.sv
// Ordered word list with insert, append, remove, get, set and clear.
// An item passes through decode, a read for a get or set that reads an entry, entry moves
// for an insert or remove that shifts entries, a final write for an accepted insert or
// append, then the response. One entry moves per cycle over the RAM's write port, and a
// new item is taken only after the last result is loaded; a stalled output holds it back.
// Reset clears the count to 0 and the size limit to 17; stored words are not cleared.
module indexed_list_insert_remove #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ilir_pkg::OP_W-1:0]     opcode,
    input  logic [ilir_pkg::INDEX_W-1:0]  index,
    input  logic [ilir_pkg::VALUE_W-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ilir_pkg::VALUE_W-1:0]  read_word,
    output logic                          ok,
    output logic [ilir_pkg::COUNT_W-1:0]  count_now,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ilir_pkg::LIMIT_W-1:0]  size_limit
);

    import ilir_pkg::*;

    localparam int AW = $clog2(DEPTH);

    state_t               state_reg, state_next;
    logic [OP_W-1:0]      op_reg;
    logic [INDEX_W-1:0]   idx_reg;
    logic [VALUE_W-1:0]   val_reg;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [VALUE_W-1:0]   res_word_reg, res_word_next;
    logic                 res_ok_reg, res_ok_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   read_word_reg, read_word_next;
    logic                 ok_reg, ok_next;
    logic [COUNT_W-1:0]   count_now_reg, count_now_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_WIDTH-1:0] ram_rdata;

    logic [WORD_WIDTH-1:0] val_word;
    logic [VALUE_W-1:0]    read_ext;
    logic                  in_range;
    logic [CMP_W-1:0]      ins_pos;
    logic [CMP_W-1:0]      grown;
    logic                  ins_ok;

    // Entry storage.
    ilir_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Word conversion between the port width and the storage width.
    assign val_word = WORD_WIDTH'(EXT_W'(val_reg));
    assign read_ext = VALUE_W'(EXT_W'(ram_rdata));

    // Range and capacity checks on the latched item.
    assign in_range = CMP_W'(idx_reg) < CMP_W'(count_reg);
    assign ins_pos  = (op_reg == OP_APPEND) ? CMP_W'(count_reg) : CMP_W'(idx_reg);
    assign grown    = CMP_W'(count_reg) + CMP_W'(1);
    assign ins_ok   = (ins_pos <= CMP_W'(count_reg)) && (grown < CMP_W'(limit_reg))
                      && (grown <= CMP_W'(DEPTH));

    // Handshake outputs.
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign read_word = read_word_reg;
    assign ok        = ok_reg;
    assign count_now = count_now_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= size_limit;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg  <= opcode;
            idx_reg <= index;
            val_reg <= value;
        end
        ptr_reg       <= ptr_next;
        pos_reg       <= pos_next;
        res_word_reg  <= res_word_next;
        res_ok_reg    <= res_ok_next;
        read_word_reg <= read_word_next;
        ok_reg        <= ok_next;
        count_now_reg <= count_now_next;
    end

    // Sequencer: next state, RAM control and result capture.
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        res_word_next  = res_word_reg;
        res_ok_next    = res_ok_reg;
        out_valid_next = out_valid_reg && out_stall;
        read_word_next = read_word_reg;
        ok_next        = ok_reg;
        count_now_next = count_now_reg;
        ram_we         = 1'b0;
        ram_waddr      = ptr_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_word_next = '0;
                res_ok_next   = 1'b0;
                state_next    = S_RESP;
                case (op_reg)
                    OP_GET:
                    begin
                        if (in_range)
                        begin
                            ram_raddr   = AW'(idx_reg);
                            res_ok_next = 1'b1;
                            state_next  = S_READ;
                        end
                        else if (count_reg != '0)
                        begin
                            ram_raddr  = '0;
                            state_next = S_READ;
                        end
                    end
                    OP_SET:
                    begin
                        if (in_range)
                        begin
                            ram_raddr   = AW'(idx_reg);
                            res_ok_next = 1'b1;
                            state_next  = S_READ;
                        end
                    end
                    OP_INSERT, OP_APPEND:
                    begin
                        if (ins_ok)
                        begin
                            res_ok_next = 1'b1;
                            pos_next    = AW'(ins_pos);
                            if (ins_pos == CMP_W'(count_reg))
                            begin
                                state_next = S_FINAL;
                            end
                            else
                            begin
                                ram_raddr  = AW'(count_reg - COUNT_W'(1));
                                ptr_next   = AW'(count_reg);
                                state_next = S_SHIFT;
                            end
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (in_range)
                        begin
                            res_ok_next = 1'b1;
                            if (CMP_W'(idx_reg) + CMP_W'(1) == CMP_W'(count_reg))
                            begin
                                count_next = count_reg - COUNT_W'(1);
                            end
                            else
                            begin
                                ram_raddr  = AW'(CMP_W'(idx_reg) + CMP_W'(1));
                                ptr_next   = AW'(idx_reg);
                                state_next = S_SHIFT;
                            end
                        end
                    end
                    OP_CLEAR:
                    begin
                        count_next  = '0;
                        res_ok_next = 1'b1;
                    end
                    default:
                    begin
                        res_ok_next = 1'b0;
                    end
                endcase
            end

            S_READ:
            begin
                // Read data is valid now; a set overwrites the entry it just read.
                res_word_next = read_ext;
                if (op_reg == OP_SET)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(idx_reg);
                    ram_wdata = val_word;
                end
                state_next = S_RESP;
            end

            S_SHIFT:
            begin
                // Write the entry read last cycle and read the next source.
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = ram_rdata;
                if (op_reg == OP_REMOVE)
                begin
                    if (CMP_W'(ptr_reg) + CMP_W'(2) == CMP_W'(count_reg))
                    begin
                        count_next = count_reg - COUNT_W'(1);
                        state_next = S_RESP;
                    end
                    else
                    begin
                        ram_raddr = AW'(CMP_W'(ptr_reg) + CMP_W'(2));
                        ptr_next  = AW'(CMP_W'(ptr_reg) + CMP_W'(1));
                    end
                end
                else
                begin
                    if (CMP_W'(ptr_reg) == CMP_W'(pos_reg) + CMP_W'(1))
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        ram_raddr = AW'(CMP_W'(ptr_reg) - CMP_W'(2));
                        ptr_next  = AW'(CMP_W'(ptr_reg) - CMP_W'(1));
                    end
                end
            end

            S_FINAL:
            begin
                // Place the new word at its position.
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = val_word;
                count_next = count_reg + COUNT_W'(1);
                state_next = S_RESP;
            end

            S_RESP:
            begin
                // Load the output register once it is free or being taken.
                if (!out_valid_reg || !out_stall)
                begin
                    read_word_next = res_word_reg;
                    ok_next        = res_ok_reg;
                    count_now_next = count_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `include "indexed_list_insert_remove_assert.svh"

    `ILIR_ASSERT_SAME(a_count_bound, 1'b1, CMP_W'(count_reg) <= CMP_W'(DEPTH), "count above depth")
    `ILIR_ASSERT_NEXT(a_idle_count, state_reg == S_IDLE, $stable(count_reg), "count moved while idle")
    `ILIR_ASSERT_SAME(a_write_busy, ram_we, state_reg != S_IDLE && state_reg != S_RESP, "stray RAM write")
    `ILIR_ASSERT_SAME(a_remove_nonempty, state_reg == S_SHIFT && op_reg == OP_REMOVE, count_reg != '0, "shift on empty list")

endmodule
